FILE: rtl/ogcu_pkg.sv
package ogcu_pkg;

  // Default store geometry.
  localparam int unsigned MaxColumnsDef = 256;
  localparam int unsigned MaxRowsDef    = 256;

  // Cost limits.
  localparam logic [7:0] MaxCost  = 8'd255;
  localparam logic [7:0] InitCost = MaxCost / 8'd2;

  // Cell type flags.
  localparam logic [7:0] FlagFree   = 8'h01;
  localparam logic [7:0] FlagOcc    = 8'h02;
  localparam logic [7:0] FlagDyn    = 8'h04;
  localparam logic [7:0] FlagQs     = 8'h08;
  localparam logic [7:0] FlagUnk    = 8'h10;
  localparam logic [7:0] FlagLimVis = 8'h20;
  localparam logic [7:0] FlagUnobs  = 8'h80;

  // A neighbor with any of these flags counts as occupied.
  localparam logic [7:0] NbrOccMask = FlagOcc | FlagQs | FlagLimVis;

  // Register reset values.
  localparam logic [7:0] FreeThrRst   = 8'd64;
  localparam logic [7:0] OccThrRst    = 8'd192;
  localparam logic [8:0] GridDimRst   = 9'd256;
  localparam logic [7:0] PermMaskRst  = 8'd96;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FREE_THR  = 3'd0,
    CFG_OCC_THR   = 3'd1,
    CFG_GRID_W    = 3'd2,
    CFG_GRID_H    = 3'd3,
    CFG_PERM_MASK = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_NBR,
    ST_TAIL,
    ST_UPDATE,
    ST_OUT
  } ogcu_state_e;

  // New type flags from cost, current type and neighbor occupancy.
  function automatic logic [7:0] classify(input logic [7:0] cost,
                                          input logic [7:0] cur,
                                          input logic [7:0] fthr,
                                          input logic [7:0] othr,
                                          input logic [7:0] pmask,
                                          input logic       near);
    logic [7:0] nt;
    if (cost <= fthr) begin
      nt = FlagFree;
    end else if (((cur & (FlagFree | FlagDyn)) != 8'd0) && (cost != MaxCost)) begin
      nt = FlagDyn;
    end else if (((cur & FlagDyn) != 8'd0) && (cost == MaxCost)) begin
      nt = near ? FlagQs : FlagDyn;
    end else if (cost >= othr) begin
      nt = ((cur & FlagQs) != 8'd0) ? FlagQs : FlagOcc;
    end else begin
      nt = ((cur & FlagQs) != 8'd0) ? FlagDyn : FlagUnk;
    end
    if ((cur & FlagLimVis) != 8'd0) begin
      nt = (nt & ~FlagDyn) | FlagOcc;
    end
    return (cur & pmask) | nt;
  endfunction

endpackage

FILE: rtl/ogcu_store.sv
module ogcu_store #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_cost_o,
  output logic [7:0]        rd_type_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_cost_i,
  input  logic [7:0]        wr_type_i,
  output logic              busy_o
);
  import ogcu_pkg::*;

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [7:0] cost_mem [Depth];
  logic [7:0] type_mem [Depth];

  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wc, wt;

  // Clearing pass after reset: one entry per cycle.
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == {ADDR_W{1'b1}}) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign we = clr_q | wr_en_i;
  assign wa = clr_q ? clr_cnt_q : wr_addr_i;
  assign wc = clr_q ? InitCost  : wr_cost_i;
  assign wt = clr_q ? FlagUnobs : wr_type_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      cost_mem[wa] <= wc;
      type_mem[wa] <= wt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_cost_o <= cost_mem[rd_addr_i];
      rd_type_o <= type_mem[rd_addr_i];
    end
  end

  assign busy_o = clr_q;

endmodule

FILE: rtl/occupancy_grid_cell_update.sv
// Occupancy grid cell update. Keeps an 8-bit cost and 8-bit type flags per
// cell (free 1, occupied 2, dynamic 4, quasi-static 8, unknown 16,
// limited-visibility 32, unobserved 128). op 0 adds a signed change
// with saturation to 0..255, op 1 sets the cost; the type is reclassified from
// the thresholds, old type and the four neighbors, permanent flags stick, and
// after op 0 a permanent cell goes to cost 255. A zero change only reads the
// cell; a cell outside the active grid returns cost 0, type 128, in_grid 0.
// Rate: one item in flight at a time. An in-grid item passes through a center
// read, four neighbor reads over the single store read port, a pipeline drain
// step, update/write and an output load before the next accept; an out-of-grid
// item goes straight to the output load. Results sit in an output register, so
// the next item is accepted while a result still waits. After reset the stores
// run a clearing pass over all 2^(clog2 cols + clog2 rows) entries, 65536 by
// default, during which no item is accepted; config writes are taken
// at any time (cfg_ready_o is always high).
module occupancy_grid_cell_update #(
  parameter int unsigned MAX_COLUMNS = ogcu_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = ogcu_pkg::MaxRowsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ogcu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [8:0]                  cfg_data_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic signed [15:0]          cell_x_i,
  input  logic signed [15:0]          cell_y_i,
  input  logic signed [7:0]           cost_change_i,
  input  logic [7:0]                  set_value_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  new_cost_o,
  output logic [7:0]                  new_type_o,
  output logic                        in_grid_o
);
  import ogcu_pkg::*;

  localparam int unsigned ColW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RowW  = $clog2(MAX_ROWS);
  localparam int unsigned AddrW = ColW + RowW;
  localparam logic [15:0] MaxCols16 = 16'(MAX_COLUMNS);
  localparam logic [15:0] MaxRows16 = 16'(MAX_ROWS);

  // ---------------------------------------------------------------- config
  logic [7:0] free_thr_q, occ_thr_q, perm_mask_q;
  logic [8:0] grid_w_q, grid_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_thr_q  <= FreeThrRst;
      occ_thr_q   <= OccThrRst;
      grid_w_q    <= GridDimRst;
      grid_h_q    <= GridDimRst;
      perm_mask_q <= PermMaskRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FREE_THR:  free_thr_q  <= cfg_data_i[7:0];
        CFG_OCC_THR:   occ_thr_q   <= cfg_data_i[7:0];
        CFG_GRID_W:    grid_w_q    <= cfg_data_i;
        CFG_GRID_H:    grid_h_q    <= cfg_data_i;
        CFG_PERM_MASK: perm_mask_q <= cfg_data_i[7:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Active grid size, clamped to the store.
  logic [15:0] act_w, act_h;
  assign act_w = (16'(grid_w_q) > MaxCols16) ? MaxCols16 : 16'(grid_w_q);
  assign act_h = (16'(grid_h_q) > MaxRows16) ? MaxRows16 : 16'(grid_h_q);

  // Negative coordinates have bit 15 set and fail the unsigned bound check.
  logic in_grid_now;
  assign in_grid_now = ($unsigned(cell_x_i) < act_w) && ($unsigned(cell_y_i) < act_h);

  // ---------------------------------------------------------------- store
  logic             st_rd_en, st_wr_en, st_busy;
  logic [AddrW-1:0] st_rd_addr, st_wr_addr;
  logic [7:0]       st_rd_cost, st_rd_type, st_wr_cost, st_wr_type;

  ogcu_store #(
    .ADDR_W(AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (st_rd_en),
    .rd_addr_i(st_rd_addr),
    .rd_cost_o(st_rd_cost),
    .rd_type_o(st_rd_type),
    .wr_en_i  (st_wr_en),
    .wr_addr_i(st_wr_addr),
    .wr_cost_i(st_wr_cost),
    .wr_type_i(st_wr_type),
    .busy_o   (st_busy)
  );

  // ---------------------------------------------------------------- item regs
  ogcu_state_e state_q, state_d;

  logic            op_q;
  logic [ColW-1:0] x_q;
  logic [RowW-1:0] y_q;
  logic [7:0]      chg_q, setv_q;
  logic            grid_q;
  logic [1:0]      nbr_cnt_q;
  logic            nok_q;      // neighbor read in flight lies in the grid
  logic            near_q;     // an occupied neighbor was seen
  logic [7:0]      ctr_cost_q, ctr_type_q;
  logic [7:0]      res_cost_q, res_type_q;

  logic       out_valid_q;
  logic [7:0] out_cost_q, out_type_q;
  logic       out_grid_q;

  // Neighbor address and range check for the read issued this cycle.
  // Order: left, right, up, down.
  logic [ColW-1:0]  nx;
  logic [RowW-1:0]  ny;
  logic             nok;

  always_comb begin
    nx  = x_q;
    ny  = y_q;
    nok = 1'b0;
    case (nbr_cnt_q)
      2'd0: begin
        nx  = x_q - 1'b1;
        nok = (x_q != '0);
      end
      2'd1: begin
        nx  = x_q + 1'b1;
        nok = (16'(x_q) + 16'd1) < act_w;
      end
      2'd2: begin
        ny  = y_q - 1'b1;
        nok = (y_q != '0);
      end
      2'd3: begin
        ny  = y_q + 1'b1;
        nok = (16'(y_q) + 16'd1) < act_h;
      end
      default: ;
    endcase
  end

  // Update arithmetic: saturating add, classification, permanent forcing.
  logic signed [9:0] sum;
  logic [7:0]        sat_cost, upd_cost, upd_type, cls_cost;
  logic              read_only;

  assign sum       = $signed({2'b00, ctr_cost_q}) + 10'(signed'(chg_q));
  assign sat_cost  = sum[9] ? 8'd0 : (sum[8] ? MaxCost : sum[7:0]);
  assign read_only = !op_q && (chg_q == 8'd0);
  assign cls_cost  = op_q ? setv_q : sat_cost;
  assign upd_type  = classify(cls_cost, ctr_type_q, free_thr_q, occ_thr_q,
                              perm_mask_q, near_q);

  always_comb begin
    if (op_q) begin
      upd_cost = setv_q;
    end else if ((upd_type & perm_mask_q) != 8'd0) begin
      upd_cost = MaxCost;
    end else begin
      upd_cost = sat_cost;
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !st_busy) begin
          state_d = in_grid_now ? ST_CENTER : ST_OUT;
        end
      end
      ST_CENTER: state_d = ST_NBR;
      ST_NBR: begin
        if (nbr_cnt_q == 2'd3) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    st_rd_en   = 1'b0;
    st_rd_addr = {y_q, x_q};
    st_wr_en   = 1'b0;
    st_wr_addr = {y_q, x_q};
    st_wr_cost = upd_cost;
    st_wr_type = upd_type;
    case (state_q)
      ST_IDLE:   in_stall_o = st_busy;
      ST_CENTER: st_rd_en = 1'b1;
      ST_NBR: begin
        st_rd_en   = 1'b1;
        st_rd_addr = {ny, nx};
      end
      ST_UPDATE: st_wr_en = !read_only;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nbr_cnt_q <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_NBR) begin
        nbr_cnt_q <= nbr_cnt_q + 2'd1;
      end else begin
        nbr_cnt_q <= 2'd0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        op_q   <= op_i;
        x_q    <= cell_x_i[ColW-1:0];
        y_q    <= cell_y_i[RowW-1:0];
        chg_q  <= cost_change_i;
        setv_q <= set_value_i;
        grid_q <= in_grid_now;
        near_q <= 1'b0;
      end
      ST_NBR: begin
        nok_q <= nok;
        if (nbr_cnt_q == 2'd0) begin
          // center read data arrives now
          ctr_cost_q <= st_rd_cost;
          ctr_type_q <= st_rd_type;
        end else if (nok_q && ((st_rd_type & NbrOccMask) != 8'd0)) begin
          near_q <= 1'b1;
        end
      end
      ST_TAIL: begin
        if (nok_q && ((st_rd_type & NbrOccMask) != 8'd0)) begin
          near_q <= 1'b1;
        end
      end
      ST_UPDATE: begin
        res_cost_q <= read_only ? ctr_cost_q : upd_cost;
        res_type_q <= read_only ? ctr_type_q : upd_type;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_cost_q <= grid_q ? res_cost_q : 8'd0;
      out_type_q <= grid_q ? res_type_q : FlagUnobs;
      out_grid_q <= grid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_cost_o  = out_cost_q;
  assign new_type_o  = out_type_q;
  assign in_grid_o   = out_grid_q;

endmodule
